/* hw/rtl/encoder_position_speed_filter_core_macros.svh */
// assertion macros for the encoder position and speed filter
`ifndef ENCODER_POSITION_SPEED_FILTER_CORE_MACROS_SVH
`define ENCODER_POSITION_SPEED_FILTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EPSF_CHECK(label, expr) label: assert property (@(posedge clk) disable iff (!arst_n) \
	(expr)) else $error("epsf check failed");
`define EPSF_CHECK_NXT(label, ante, cons) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (ante) |=> (cons)) else $error("epsf next check failed");
`else
`define EPSF_CHECK(label, expr)
`define EPSF_CHECK_NXT(label, ante, cons)
`endif
`endif

/* hw/rtl/epsf_pkg.sv */
// types, constants and helpers for the encoder position and speed filter
package epsf_pkg;
	localparam int COUNTER_WIDTH = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int COEF_W = 25;
	localparam int MUL_ITER = COEF_W;
	localparam int NUM_BANDS = 12;

	localparam logic [2:0] REG_PPR = 3'd0;
	localparam logic [2:0] REG_FACTOR = 3'd1;
	localparam logic [2:0] REG_FILT_EN = 3'd2;
	localparam logic [2:0] REG_CUTOFF = 3'd3;
	localparam logic [2:0] REG_RELOAD = 3'd4;

	typedef enum logic {OP_MUL = 1'b0, OP_DIV = 1'b1} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [63:0] opa;
		logic [63:0] opb;
	} unit_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

	typedef logic [NUM_BANDS-1:0][31:0] e8_tab_t;
	typedef logic [NUM_BANDS-1:0][COEF_W-1:0] coef_tab_t;

	localparam e8_tab_t BAND_B = {
		32'd50390953, 32'd54029650, 32'd57848789, 32'd61862133, 32'd66084882, 32'd70533864,
		32'd75227759, 32'd80187364, 32'd85435899, 32'd90999367, 32'd93908194, 32'd96906992};
	localparam e8_tab_t BAND_A = {
		32'd24804523, 32'd22985175, 32'd21075605, 32'd19068933, 32'd16957559, 32'd14733068,
		32'd12386120, 32'd9906318, 32'd7282051, 32'd4500317, 32'd3045903, 32'd1546504};

	function automatic coef_tab_t coef_table(input e8_tab_t e8, input int frac);
		coef_tab_t   t;
		logic [63:0] v;
		for (int i = 0; i < NUM_BANDS; i++) begin
			v = ((64'(e8[i]) << frac) + 64'd50000000) / 64'd100000000;
			t[i] = v[COEF_W-1:0];
		end
		return t;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
		if (v > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
		if (v < -64'sd549755813888) return 40'sh80_0000_0000;
		return v[39:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) return 48'sh7FFF_FFFF_FFFF;
		if (v < -64'sd140737488355328) return 48'sh8000_0000_0000;
		return v[47:0];
	endfunction
endpackage

/* hw/rtl/encoder_position_speed_filter_core.sv */
// top level: sample intake, sequencer over the shared unit, result register
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | counter_value[15:0]                         | counting_down
//  m_axis  | out | position_count, count_delta, position_units,| -
//          |     | speed_rpm, speed_units (176 bits)           |
//  cfg     | in  | cfg_index selects register, cfg_data value  | -
// unit ops run UMUL, UDIV, RMUL, RDIV, then SDIV; the filter adds FB, FA0 and FA1;
// each shared unit op has a start step, its iterations and a done step:
// a multiply or a divide, plus a step to scale rpm and, with the filter, a step for filter out
// s_tready is high only while idle with no result pending; the result holds on m_axis until taken
// arst_n clears control and encoder state and loads the configuration defaults
module encoder_position_speed_filter_core import epsf_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // counter_value
	input  logic          s_tuser,   // counting_down
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [175:0]  m_tdata,   // position_count, count_delta, position_units,
	                                 // speed_rpm, speed_units
	input  logic          cfg_wr_en,
	input  logic [2:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
	`include "encoder_position_speed_filter_core_macros.svh"

	localparam coef_tab_t B_TAB = coef_table(BAND_B, COEF_FRAC_BITS);
	localparam coef_tab_t A_TAB = coef_table(BAND_A, COEF_FRAC_BITS);
	localparam logic [63:0] FRAC_HALF = 64'd1 << (COEF_FRAC_BITS - 1);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b00000000001,
		ST_UMUL = 11'b00000000010,
		ST_UDIV = 11'b00000000100,
		ST_RMUL = 11'b00000001000,
		ST_RDIV = 11'b00000010000,
		ST_FB   = 11'b00000100000,
		ST_FA0  = 11'b00001000000,
		ST_FA1  = 11'b00010000000,
		ST_FOUT = 11'b00100000000,
		ST_RPM  = 11'b01000000000,
		ST_SDIV = 11'b10000000000
	} state_t;

	state_t state_q;
	logic   out_vld_q;
	logic   issued_q;

	logic [15:0] ppr_q;
	logic [23:0] factor_q;
	logic        filt_en_q;
	logic [7:0]  cutoff_q;
	logic [15:0] reload_q;

	logic [COUNTER_WIDTH-1:0] last_q;
	logic                     seen_q;
	logic signed [31:0]       pos_q;
	logic signed [15:0]       delta_q;
	logic signed [39:0]       fout_q;
	logic signed [39:0]       fin_q;

	logic                neg_q;
	logic [63:0]         tmp_q;
	logic signed [63:0]  acc_q;
	logic signed [47:0]  units_q;
	logic signed [39:0]  rps_q;
	logic signed [39:0]  rpm_q;
	logic signed [39:0]  spu_q;

	unit_cmd_t cmd;
	unit_rsp_t rsp;

	logic               in_acc;
	logic [COUNTER_WIDTH-1:0] cnt_in;
	logic signed [17:0] cs, ls, rs, d_raw;
	logic signed [15:0] d_sat;
	logic [15:0]        ppr_eff;
	logic [17:0]        cpr;
	logic [23:0]        fac_eff;
	logic [3:0]         band;
	logic [COEF_W-1:0]  b_coef, a_coef;
	logic signed [63:0] res_s;
	logic [63:0]        acc_mag, fq;
	logic signed [47:0] rps48, rpm_raw;
	logic signed [39:0] y_new, rpm_new;

	epsf_unit u_unit (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	assign s_tready = (state_q == ST_IDLE) && !out_vld_q;
	assign in_acc = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata = {spu_q, rpm_q, units_q, delta_q, pos_q};

	assign ppr_eff = (ppr_q == '0) ? 16'd1 : ppr_q;
	assign cpr = {ppr_eff, 2'b00};
	assign fac_eff = (factor_q == '0) ? 24'd1 : factor_q;

	always_comb begin
		case (cutoff_q) inside
			[8'd0:8'd5]:   band = 4'd0;
			[8'd6:8'd10]:  band = 4'd1;
			[8'd11:8'd15]: band = 4'd2;
			[8'd16:8'd25]: band = 4'd3;
			[8'd26:8'd35]: band = 4'd4;
			[8'd36:8'd45]: band = 4'd5;
			[8'd46:8'd55]: band = 4'd6;
			[8'd56:8'd65]: band = 4'd7;
			[8'd66:8'd75]: band = 4'd8;
			[8'd76:8'd85]: band = 4'd9;
			[8'd86:8'd95]: band = 4'd10;
			default:       band = 4'd11;
		endcase
	end
	assign b_coef = B_TAB[band];
	assign a_coef = A_TAB[band];

	// wrap-aware delta
	assign cnt_in = s_tdata[COUNTER_WIDTH-1:0];
	assign cs = signed'(18'(cnt_in));
	assign ls = signed'(18'(last_q));
	assign rs = signed'(18'(reload_q));
	always_comb begin
		d_raw = '0;
		if (seen_q) begin
			if (cnt_in > last_q)
				d_raw = s_tuser ? (cs - ls - rs) : (cs - ls);
			else if (cnt_in < last_q)
				d_raw = s_tuser ? (cs - ls) : (cs + rs - ls);
		end
		if (d_raw > 18'sd32767)
			d_sat = 16'sh7FFF;
		else if (d_raw < -18'sd32768)
			d_sat = 16'sh8000;
		else
			d_sat = d_raw[15:0];
	end

	assign res_s = neg_q ? -signed'(rsp.result) : signed'(rsp.result);
	assign acc_mag = mag64(acc_q);
	assign fq = (acc_mag + FRAC_HALF) >> COEF_FRAC_BITS;
	assign y_new = sat40(acc_q[63] ? -signed'(fq) : signed'(fq));
	assign rps48 = 48'(rps_q);
	assign rpm_raw = (rps48 <<< 6) - (rps48 <<< 2);
	assign rpm_new = sat40(64'(rpm_raw));

	always_comb begin
		cmd.start = 1'b0;
		cmd.op = OP_MUL;
		cmd.opa = tmp_q;
		cmd.opb = 64'(cpr);
		case (state_q)
			ST_UMUL: begin
				cmd.start = !issued_q;
				cmd.opa = mag64(64'(pos_q));
				cmd.opb = 64'(factor_q);
			end
			ST_UDIV, ST_RDIV: begin
				cmd.start = !issued_q;
				cmd.op = OP_DIV;
			end
			ST_RMUL: begin
				cmd.start = !issued_q;
				cmd.opa = mag64(64'(delta_q));
				cmd.opb = 64'd256000;
			end
			ST_FB: begin
				cmd.start = !issued_q;
				cmd.opa = mag64(64'(fout_q));
				cmd.opb = 64'(b_coef);
			end
			ST_FA0: begin
				cmd.start = !issued_q;
				cmd.opa = mag64(64'(rps_q));
				cmd.opb = 64'(a_coef);
			end
			ST_FA1: begin
				cmd.start = !issued_q;
				cmd.opa = mag64(64'(fin_q));
				cmd.opb = 64'(a_coef);
			end
			ST_SDIV: begin
				cmd.start = !issued_q;
				cmd.op = OP_DIV;
				cmd.opb = 64'(fac_eff);
			end
			default: cmd.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= 16'd2048;
			factor_q <= 24'd65536;
			filt_en_q <= 1'b0;
			cutoff_q <= 8'd20;
			reload_q <= 16'd65535;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PPR:     ppr_q <= cfg_data[15:0];
				REG_FACTOR:  factor_q <= cfg_data;
				REG_FILT_EN: filt_en_q <= cfg_data[0];
				REG_CUTOFF:  cutoff_q <= cfg_data[7:0];
				REG_RELOAD:  reload_q <= cfg_data[15:0];
				default:     ppr_q <= ppr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vld_q <= 1'b0;
			issued_q <= 1'b0;
			last_q <= '0;
			seen_q <= 1'b0;
			pos_q <= '0;
			fout_q <= '0;
			fin_q <= '0;
		end else begin
			if (cmd.start)
				issued_q <= 1'b1;
			else if (rsp.done)
				issued_q <= 1'b0;
			if (out_vld_q && m_tready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						seen_q <= 1'b1;
						last_q <= cnt_in;
						pos_q <= pos_q + 32'(d_sat);
						state_q <= ST_UMUL;
					end
				end
				ST_UMUL: if (rsp.done && issued_q) state_q <= ST_UDIV;
				ST_UDIV: if (rsp.done && issued_q) state_q <= ST_RMUL;
				ST_RMUL: if (rsp.done && issued_q) state_q <= ST_RDIV;
				ST_RDIV: begin
					if (rsp.done && issued_q)
						state_q <= filt_en_q ? ST_FB : ST_RPM;
				end
				ST_FB:   if (rsp.done && issued_q) state_q <= ST_FA0;
				ST_FA0:  if (rsp.done && issued_q) state_q <= ST_FA1;
				ST_FA1:  if (rsp.done && issued_q) state_q <= ST_FOUT;
				ST_FOUT: begin
					fin_q <= rps_q;
					fout_q <= y_new;
					state_q <= ST_RPM;
				end
				ST_RPM:  state_q <= ST_SDIV;
				ST_SDIV: begin
					if (rsp.done && issued_q) begin
						out_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath captures
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					delta_q <= d_sat;
					neg_q <= pos_q[31] ^ 1'b0;
				end
			end
			ST_UMUL: begin
				neg_q <= pos_q[31];
				if (rsp.done && issued_q)
					tmp_q <= rsp.result + 64'({ppr_eff, 1'b0});
			end
			ST_UDIV: begin
				if (rsp.done && issued_q) begin
					units_q <= sat48(res_s);
					neg_q <= delta_q[15];
				end
			end
			ST_RMUL: begin
				if (rsp.done && issued_q)
					tmp_q <= rsp.result + 64'({ppr_eff, 1'b0});
			end
			ST_RDIV: begin
				if (rsp.done && issued_q) begin
					rps_q <= res_s[39:0];
					neg_q <= fout_q[39];
					acc_q <= '0;
				end
			end
			ST_FB: begin
				if (rsp.done && issued_q) begin
					acc_q <= acc_q + res_s;
					neg_q <= rps_q[39];
				end
			end
			ST_FA0: begin
				if (rsp.done && issued_q) begin
					acc_q <= acc_q + res_s;
					neg_q <= fin_q[39];
				end
			end
			ST_FA1: if (rsp.done && issued_q) acc_q <= acc_q + res_s;
			ST_FOUT: rps_q <= y_new;
			ST_RPM: begin
				rpm_q <= rpm_new;
				neg_q <= rpm_new[39];
				tmp_q <= (mag64(64'(rpm_new)) << 16) + 64'(fac_eff >> 1);
			end
			ST_SDIV: if (rsp.done && issued_q) spu_q <= sat40(res_s);
			default: neg_q <= neg_q;
		endcase
	end

	`EPSF_CHECK(a_ready_valid_excl, !(s_tready && m_tvalid))
	`EPSF_CHECK_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !m_tvalid)
	`EPSF_CHECK_NXT(a_idle_after_take, m_tvalid && m_tready, s_tready)
	`EPSF_CHECK(a_start_only_once, !(cmd.start && issued_q))
endmodule

/* hw/rtl/epsf_unit.sv */
// shared shift-add multiplier and restoring divider, one bit per cycle
module epsf_unit import epsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  unit_cmd_t cmd,
	output unit_rsp_t rsp
);
	logic        busy_q;
	logic        done_q;
	op_t         op_q;
	logic [5:0]  cnt_q;
	logic [63:0] acc_q;
	logic [63:0] sh_q;
	logic [63:0] mb_q;
	logic [63:0] rem_sh;

	assign rem_sh = {acc_q[62:0], sh_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= OP_MUL;
			cnt_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			op_q <= cmd.op;
			cnt_q <= (cmd.op == OP_MUL) ? 6'(MUL_ITER - 1) : 6'd63;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			sh_q <= cmd.opa;
			mb_q <= cmd.opb;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (mb_q[0])
						acc_q <= acc_q + sh_q;
					sh_q <= {sh_q[62:0], 1'b0};
					mb_q <= {1'b0, mb_q[63:1]};
				end
				OP_DIV: begin
					if (rem_sh >= mb_q) begin
						acc_q <= rem_sh - mb_q;
						sh_q <= {sh_q[62:0], 1'b1};
					end else begin
						acc_q <= rem_sh;
						sh_q <= {sh_q[62:0], 1'b0};
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = (op_q == OP_MUL) ? acc_q : sh_q;
endmodule
